[src/interprocessor_interrupt_controller_defines.svh]
// Assertion macros used by the interprocessor interrupt controller.
`ifndef INTERPROCESSOR_INTERRUPT_CONTROLLER_DEFINES_SVH
`define INTERPROCESSOR_INTERRUPT_CONTROLLER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define IIC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iic: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define IIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iic: next-cycle check failed");

`endif

[src/iic_pkg.sv]
// Shared types and constants of the interprocessor interrupt controller.
package iic_pkg;

  localparam int unsigned CORE_COUNT = 4;
  localparam int unsigned IDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int unsigned REG_W = 32;
  localparam int unsigned IRQ_W = 4;

  localparam logic [REG_W-1:0] CTRL_GEN_BIT = 32'h4000_0000;
  localparam logic [REG_W-1:0] CTRL_ACK_BIT = 32'h8000_0000;
  localparam logic [15:0] DATA_MASK = 16'hffff;
  localparam logic [13:0] DEST_MASK = 14'h3fff;
  localparam int unsigned DEST_SHIFT = 16;

  localparam logic MODE_READ = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic SEL_CONTROL = 1'b0;
  localparam logic SEL_STATUS = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [1:0]  core_index;
    logic        register_select;
    logic [31:0] write_data;
  } iic_req_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic [IRQ_W-1:0] irq_lines;
    logic             request_ignored;
    logic             access_error;
  } iic_rsp_t;

  // Write commands from the access logic to the register store.
  typedef struct packed {
    logic             ctrl_en;
    logic [IDX_W-1:0] ctrl_addr;
    logic [REG_W-1:0] ctrl_data;
    logic             stat_en;
    logic [IDX_W-1:0] stat_addr;
    logic [REG_W-1:0] stat_data;
  } iic_wr_t;

endpackage

[src/iic_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module iic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/iic_regs.sv]
// Control and status register store: two RAMs plus per-entry written flags.
module iic_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  re,
  input  logic [iic_pkg::IDX_W-1:0]             raddr,
  input  iic_pkg::iic_wr_t                      wr,
  output logic [iic_pkg::REG_W-1:0]             ctrl_rd,
  output logic [iic_pkg::REG_W-1:0]             stat_rd
);
  import iic_pkg::*;

  logic [CORE_COUNT-1:0] ctrl_vld;
  logic [CORE_COUNT-1:0] stat_vld;
  logic                  ctrl_vld_rd;
  logic                  stat_vld_rd;
  logic [REG_W-1:0]      ctrl_ram_rd;
  logic [REG_W-1:0]      stat_ram_rd;

  iic_ram #(.WIDTH(REG_W), .DEPTH(CORE_COUNT)) u_ctrl_ram (
    .clk   (clk),
    .we    (wr.ctrl_en),
    .waddr (wr.ctrl_addr),
    .wdata (wr.ctrl_data),
    .re    (re),
    .raddr (raddr),
    .rdata (ctrl_ram_rd)
  );

  iic_ram #(.WIDTH(REG_W), .DEPTH(CORE_COUNT)) u_stat_ram (
    .clk   (clk),
    .we    (wr.stat_en),
    .waddr (wr.stat_addr),
    .wdata (wr.stat_data),
    .re    (re),
    .raddr (raddr),
    .rdata (stat_ram_rd)
  );

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_vld    <= '0;
      stat_vld    <= '0;
      ctrl_vld_rd <= 1'b0;
      stat_vld_rd <= 1'b0;
    end else begin
      if (wr.ctrl_en) begin
        ctrl_vld[wr.ctrl_addr] <= 1'b1;
      end
      if (wr.stat_en) begin
        stat_vld[wr.stat_addr] <= 1'b1;
      end
      if (re) begin
        ctrl_vld_rd <= ctrl_vld[raddr];
        stat_vld_rd <= stat_vld[raddr];
      end
    end
  end

  assign ctrl_rd = ctrl_vld_rd ? ctrl_ram_rd : '0;
  assign stat_rd = stat_vld_rd ? stat_ram_rd : '0;

endmodule

[src/interprocessor_interrupt_controller.sv]
// Interprocessor interrupt controller: register access handling and result register.
//
// Usage: the request channel (req_valid, req_stall, req) carries one register
// access per transaction: a read or write of a core's control register, or a
// read of its status register. The response channel (rsp_valid, rsp_stall, rsp)
// returns one result per request: read data, the interrupt lines after the
// access, and the ignored and error flags.
// Flow: the registers live in synchronous RAMs, read at the edge that accepts
// a request; the EXEC state then decides, writes back and loads the result
// register. No new request is taken while one is in EXEC; a new request is
// taken in the cycle its predecessor's response is taken.
// Reset: all registers and interrupt lines read as zero; no clearing pass.
// Stall: while the response is stalled it holds, and no new request is taken.
module interprocessor_interrupt_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  iic_pkg::iic_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output iic_pkg::iic_rsp_t rsp
);
  import iic_pkg::*;

  `include "interprocessor_interrupt_controller_defines.svh"

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                state;
  iic_req_t              item;
  logic [CORE_COUNT-1:0] pending;
  logic [CORE_COUNT-1:0] pending_next;
  logic                  req_accept;
  iic_wr_t               wr;
  logic [REG_W-1:0]      ctrl_rd;
  logic [REG_W-1:0]      stat_rd;
  iic_rsp_t              rsp_next;

  logic [IDX_W-1:0]      acc_core;
  logic [13:0]           dest;
  logic [IDX_W-1:0]      dest_idx;
  logic                  core_ok;
  logic                  dest_ok;
  logic                  wr_ok;

  assign req_stall  = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign req_accept = req_valid && !req_stall;

  iic_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .re      (req_accept),
    .raddr   (IDX_W'(req.core_index)),
    .wr      (wr),
    .ctrl_rd (ctrl_rd),
    .stat_rd (stat_rd)
  );

  assign acc_core = IDX_W'(item.core_index);
  assign dest     = item.write_data[DEST_SHIFT +: 14] & DEST_MASK;
  assign dest_idx = IDX_W'(dest);
  assign core_ok  = 32'(item.core_index) < CORE_COUNT;
  assign dest_ok  = 32'(dest) < CORE_COUNT;
  assign wr_ok    = core_ok && (item.mode == MODE_WRITE) &&
                    (item.register_select == SEL_CONTROL) && dest_ok;

  always_comb begin
    wr = '0;
    wr.ctrl_addr = acc_core;
    wr.ctrl_data = item.write_data;
    wr.stat_addr = dest_idx;
    wr.stat_data = (REG_W'(item.core_index) << DEST_SHIFT) |
                   REG_W'(item.write_data[15:0] & DATA_MASK);
    pending_next = pending;
    if ((state == ST_EXEC) && wr_ok) begin
      wr.ctrl_en = 1'b1;
      // GEN lands first so that an ACK to oneself clears the line again.
      if ((item.write_data & CTRL_GEN_BIT) != '0) begin
        wr.stat_en = 1'b1;
        pending_next[dest_idx] = 1'b1;
      end
      if ((item.write_data & CTRL_ACK_BIT) != '0) begin
        pending_next[acc_core] = 1'b0;
      end
    end
  end

  always_comb begin
    rsp_next = '0;
    if (!core_ok) begin
      rsp_next.access_error = 1'b1;
    end else if (item.mode == MODE_READ) begin
      if (item.register_select == SEL_STATUS) begin
        rsp_next.read_data = stat_rd | (pending[acc_core] ? CTRL_GEN_BIT : '0);
      end else begin
        rsp_next.read_data = ctrl_rd;
      end
    end else if (item.register_select == SEL_STATUS) begin
      rsp_next.access_error = 1'b1;
    end else if (!dest_ok) begin
      rsp_next.request_ignored = 1'b1;
    end
    for (int n = 0; n < IRQ_W; n++) begin
      if (n < CORE_COUNT) begin
        rsp_next.irq_lines[n] = pending_next[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_accept) begin
            item  <= req;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          pending   <= pending_next;
          rsp       <= rsp_next;
          rsp_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `IIC_ASSERT_NEXT(a_accept_to_exec, clk, rst, req_accept, state == ST_EXEC)
  `IIC_ASSERT_NEXT(a_exec_to_rsp, clk, rst, state == ST_EXEC, rsp_valid)
  `IIC_ASSERT_SAME(a_flags_exclusive, clk, rst, rsp_valid,
                   !(rsp.request_ignored && rsp.access_error))
  `IIC_ASSERT_SAME(a_exec_rsp_free, clk, rst, state == ST_EXEC, !rsp_valid)

endmodule
